// ----- rtl/core/smc_pkg.sv -----
// Sliding mode controller package: register indexes, widths and shared types.
// Used by smc_ctrl, smc_dp and sliding_mode_controller.
package smc_pkg;
    localparam int W = 32;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOPE  = 3'd0,
        REG_GAIN   = 3'd1,
        REG_PHI    = 3'd2,
        REG_SATMD  = 3'd3,
        REG_A0     = 3'd4,
        REG_A1     = 3'd5,
        REG_B      = 3'd6,
        REG_DT     = 3'd7
    } t_reg_idx;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL,
        OP_DIV,
        OP_ERR,
        OP_ED,
        OP_S,
        OP_RDN,
        OP_RD,
        OP_NUM,
        OP_UEQ,
        OP_USW,
        OP_OUT
    } t_op;

    // operand select codes
    localparam logic [3:0] S_SLOPE_E   = 4'd0;
    localparam logic [3:0] S_A0_Y      = 4'd1;
    localparam logic [3:0] S_A1_ED     = 4'd2;
    localparam logic [3:0] S_SLOPE_RD  = 4'd3;
    localparam logic [3:0] S_SLOPE_ED  = 4'd4;
    localparam logic [3:0] S_GAIN_S    = 4'd5;
    localparam logic [3:0] S_DIV_ED    = 4'd6;
    localparam logic [3:0] S_DIV_RD    = 4'd7;
    localparam logic [3:0] S_DIV_UEQ   = 4'd8;
    localparam logic [3:0] S_DIV_USW   = 4'd9;

    typedef struct packed {
        t_op        op;
        logic [3:0] sel;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic dt_zero;
    } t_sts;

    function automatic logic signed [W-1:0] sat32(input logic signed [79:0] v);
        if (v > 80'sd2147483647) return 32'sh7fffffff;
        if (v < -80'sd2147483648) return 32'sh80000000;
        return v[W-1:0];
    endfunction
endpackage

// ----- rtl/core/smc_dp.sv -----
// Sliding mode controller datapath: operand registers, serial multiplier
// and serial divider. Depends on smc_pkg; driven by smc_ctrl.
module smc_dp import smc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic signed [W-1:0] i_ref,
    input  logic signed [W-1:0] i_meas,
    input  logic signed [W-1:0] i_slope,
    input  logic signed [W-1:0] i_gain,
    input  logic [30:0]         i_phi,
    input  logic                i_satmd,
    input  logic signed [W-1:0] i_a0,
    input  logic signed [W-1:0] i_a1,
    input  logic signed [W-1:0] i_b,
    input  logic [30:0]         i_dt,
    output logic signed [W-1:0] o_drive,
    output logic signed [W-1:0] o_surface
);
    logic signed [W-1:0] r_ref, r_y, r_e, r_last, r_ed, r_s, r_rd, r_ueq, r_usw;
    logic signed [49:0]  r_num;
    logic signed [49:0]  r_rdn;
    logic signed [W-1:0] r_drive, r_surf;

    // shift-add multiplier
    logic [63:0] r_macc;
    logic [31:0] r_mb;
    logic [62:0] r_ma;
    logic        r_mneg;
    logic [5:0]  r_mcnt;
    // restoring divider: 82-bit dividend
    logic [81:0] r_dq;
    logic [63:0] r_drem;
    logic [63:0] r_dden;
    logic        r_dneg;
    logic [6:0]  r_dcnt;

    logic signed [W-1:0] m_a, m_b;
    logic signed [81:0]  d_n;
    logic signed [63:0]  d_d;
    logic [31:0] ma_abs, mb_abs;
    logic [81:0] dn_abs;
    logic [63:0] dd_abs;
    logic [64:0] trial;
    logic signed [64:0] mprod;
    logic signed [63:0] mq;
    logic signed [82:0] dquo;

    always_comb begin
        m_a = i_slope; m_b = r_e;
        d_n = '0; d_d = 64'sd1;
        unique case (i_cmd.sel)
            S_SLOPE_E:  begin m_a = i_slope; m_b = r_e;   end
            S_A0_Y:     begin m_a = i_a0;    m_b = r_y;   end
            S_A1_ED:    begin m_a = i_a1;    m_b = r_ed;  end
            S_SLOPE_RD: begin m_a = i_slope; m_b = r_rd;  end
            S_SLOPE_ED: begin m_a = i_slope; m_b = r_ed;  end
            S_GAIN_S:   begin m_a = i_gain;  m_b = r_s;   end
            S_DIV_ED: begin
                d_n = (82'(r_e) - 82'(r_last)) <<< 16;
                d_d = 64'({1'b0, i_dt});
            end
            S_DIV_RD: begin
                d_n = 82'(r_rdn) <<< 16;
                d_d = 64'({1'b0, i_dt});
            end
            S_DIV_UEQ: begin
                d_n = 82'(r_num) <<< 16;
                d_d = 64'(i_b);
            end
            S_DIV_USW: begin
                d_n = 82'(signed'(r_macc));
                d_d = 64'({1'b0, i_phi});
            end
            default: ;
        endcase
        ma_abs = m_a[W-1] ? 32'(-m_a) : 32'(m_a);
        mb_abs = m_b[W-1] ? 32'(-m_b) : 32'(m_b);
        dn_abs = d_n[81] ? 82'(-d_n) : 82'(d_n);
        dd_abs = d_d[63] ? 64'(-d_d) : 64'(d_d);
        trial  = {r_drem[63:0], r_dq[81]} - {1'b0, r_dden};
        mprod  = r_mneg ? -$signed({1'b0, r_macc}) : $signed({1'b0, r_macc});
        mq     = 64'(mprod >>> 16);
        if (mprod < 0 && mprod[15:0] != 16'd0) mq = mq + 64'sd1;
        dquo   = r_dneg ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcnt <= '0;
            r_dcnt <= '0;
            r_last <= '0;
        end else begin
            if (r_mcnt != 0) begin
                if (r_mb[0]) r_macc <= r_macc + 64'(r_ma);
                r_ma   <= r_ma << 1;
                r_mb   <= r_mb >> 1;
                r_mcnt <= r_mcnt - 6'd1;
            end
            if (r_dcnt != 0) begin
                if (!trial[64]) begin
                    r_drem <= trial[63:0];
                    r_dq   <= {r_dq[80:0], 1'b1};
                end else begin
                    r_drem <= {r_drem[62:0], r_dq[81]};
                    r_dq   <= {r_dq[80:0], 1'b0};
                end
                r_dcnt <= r_dcnt - 7'd1;
            end
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_ref <= i_ref;
                    r_y   <= i_meas;
                end
                OP_ERR: r_e <= sat32(80'(r_ref) - 80'(r_y));
                OP_MUL: begin
                    r_macc <= '0;
                    r_ma   <= 63'(ma_abs);
                    r_mb   <= mb_abs;
                    r_mneg <= m_a[W-1] ^ m_b[W-1];
                    r_mcnt <= 6'd32;
                end
                OP_DIV: begin
                    r_dq   <= dn_abs;
                    r_drem <= '0;
                    r_dden <= dd_abs;
                    r_dneg <= d_n[81] ^ d_d[63];
                    r_dcnt <= 7'd82;
                end
                OP_ED:  r_ed <= sat32(80'(dquo));
                OP_S:   r_s  <= sat32(80'(r_ed) + 80'(sat32(80'(mq))));
                OP_RDN: begin
                    r_rdn <= 50'(r_ref) - 50'(r_e) + 50'(r_ed);
                    r_num <= '0;
                end
                OP_RD:  r_rd <= sat32(80'(dquo));
                OP_NUM: r_num <= r_num + 50'(sat32(80'(mq)));
                OP_UEQ: begin
                    if (i_b == 0)
                        r_ueq <= (r_num > 0) ? 32'sh7fffffff :
                                 (r_num < 0) ? 32'sh80000000 : 32'sd0;
                    else
                        r_ueq <= sat32(80'(dquo));
                end
                OP_USW: begin
                    // r_macc holds |K*s| magnitude; restore sign as full product
                    if (i_cmd.sel == S_GAIN_S) begin
                        r_macc <= 64'(mprod);
                    end else begin
                        if (!i_satmd) begin
                            r_usw <= (r_s > 0) ? i_gain :
                                     (r_s < 0) ? sat32(-80'(i_gain)) : 32'sd0;
                        end else if ((r_s[W-1] ? -65'(r_s) : 65'(r_s)) <= 65'(i_phi)) begin
                            r_usw <= (i_phi == 0) ? 32'sd0 : sat32(80'(dquo));
                        end else begin
                            r_usw <= (r_s > 0) ? i_gain : sat32(-80'(i_gain));
                        end
                    end
                end
                OP_OUT: begin
                    r_drive <= sat32(80'(r_ueq) - 80'(r_usw));
                    r_surf  <= r_s;
                    r_last  <= r_e;
                end
                default: ;
            endcase
        end
    end

    assign o_sts.busy    = (r_mcnt != 0) || (r_dcnt != 0);
    assign o_sts.dt_zero = (i_dt == 0);
    assign o_drive   = r_drive;
    assign o_surface = r_surf;
endmodule

// ----- rtl/core/smc_ctrl.sv -----
// Sliding mode controller sequencer: steps the datapath through one sample.
// Depends on smc_pkg.
module smc_ctrl import smc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [5:0] {
        ST_IDLE, ST_ERR, ST_DED, ST_WED, ST_ED, ST_MS, ST_WS, ST_S, ST_RDN,
        ST_DRD, ST_WRD, ST_RD, ST_M0, ST_W0, ST_N0, ST_M1, ST_W1, ST_N1,
        ST_M2, ST_W2, ST_N2, ST_M3, ST_W3, ST_N3, ST_DU, ST_WU, ST_UEQ,
        ST_MK, ST_WK, ST_PK, ST_DK, ST_WDK, ST_USW, ST_OUT, ST_HOLD
    } t_state;
    t_state r_state, n_state;
    logic   r_out_valid;
    t_cmd   c;

    always_comb begin
        n_state = r_state;
        c = '{op: OP_NONE, sel: S_SLOPE_E};
        unique case (r_state)
            ST_IDLE: if (i_in_valid) begin
                c.op = OP_LOAD;
                n_state = i_sts.dt_zero ? ST_IDLE : ST_ERR;
            end
            ST_ERR: begin c.op = OP_ERR; n_state = ST_DED; end
            ST_DED: begin c = '{OP_DIV, S_DIV_ED}; n_state = ST_WED; end
            ST_WED: if (!i_sts.busy) n_state = ST_ED;
            ST_ED:  begin c = '{OP_ED, S_DIV_ED}; n_state = ST_MS; end
            ST_MS:  begin c = '{OP_MUL, S_SLOPE_E}; n_state = ST_WS; end
            ST_WS:  if (!i_sts.busy) n_state = ST_S;
            ST_S:   begin c.op = OP_S; n_state = ST_RDN; end
            ST_RDN: begin c.op = OP_RDN; n_state = ST_DRD; end
            ST_DRD: begin c = '{OP_DIV, S_DIV_RD}; n_state = ST_WRD; end
            ST_WRD: if (!i_sts.busy) n_state = ST_RD;
            ST_RD:  begin c = '{OP_RD, S_DIV_RD}; n_state = ST_M0; end
            ST_M0:  begin c = '{OP_MUL, S_A0_Y}; n_state = ST_W0; end
            ST_W0:  if (!i_sts.busy) n_state = ST_N0;
            ST_N0:  begin c.op = OP_NUM; n_state = ST_M1; end
            ST_M1:  begin c = '{OP_MUL, S_A1_ED}; n_state = ST_W1; end
            ST_W1:  if (!i_sts.busy) n_state = ST_N1;
            ST_N1:  begin c.op = OP_NUM; n_state = ST_M2; end
            ST_M2:  begin c = '{OP_MUL, S_SLOPE_RD}; n_state = ST_W2; end
            ST_W2:  if (!i_sts.busy) n_state = ST_N2;
            ST_N2:  begin c.op = OP_NUM; n_state = ST_M3; end
            ST_M3:  begin c = '{OP_MUL, S_SLOPE_ED}; n_state = ST_W3; end
            ST_W3:  if (!i_sts.busy) n_state = ST_N3;
            ST_N3:  begin c.op = OP_NUM; n_state = ST_DU; end
            ST_DU:  begin c = '{OP_DIV, S_DIV_UEQ}; n_state = ST_WU; end
            ST_WU:  if (!i_sts.busy) n_state = ST_UEQ;
            ST_UEQ: begin c = '{OP_UEQ, S_DIV_UEQ}; n_state = ST_MK; end
            ST_MK:  begin c = '{OP_MUL, S_GAIN_S}; n_state = ST_WK; end
            ST_WK:  if (!i_sts.busy) n_state = ST_PK;
            ST_PK:  begin c = '{OP_USW, S_GAIN_S}; n_state = ST_DK; end
            ST_DK:  begin c = '{OP_DIV, S_DIV_USW}; n_state = ST_WDK; end
            ST_WDK: if (!i_sts.busy) n_state = ST_USW;
            ST_USW: begin c = '{OP_USW, S_DIV_USW}; n_state = ST_OUT; end
            ST_OUT: if (!r_out_valid || i_out_ready) begin
                c.op = OP_OUT; n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (c.op == OP_OUT) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_cmd = c;
    assign o_in_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

// ----- rtl/core/sliding_mode_controller.sv -----
// Sliding mode controller with boundary layer, signed Q16.16 saturating.
// A sample is taken only once the previous one is through: six products on
// a serial shift-add multiplier and four quotients on a restoring divider,
// run one after another, plus load, error, numerator setup and output.
// The result sits in an output register, so the next word is taken while it
// waits. A sample with zero period is consumed silently.
// Top level; depends on smc_pkg, smc_ctrl, smc_dp.
module sliding_mode_controller import smc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [W-1:0] i_reference,
    input  logic signed [W-1:0] i_measured,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [W-1:0] o_drive,
    output logic signed [W-1:0] o_surface,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [W-1:0]        i_cfg_data
);
    logic signed [W-1:0] r_slope, r_gain, r_a0, r_a1, r_b;
    logic [30:0] r_phi, r_dt;
    logic        r_satmd;
    t_cmd cmd;
    t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slope <= 32'sd65536; r_gain <= 32'sd65536; r_phi <= 31'd65536;
            r_satmd <= 1'b1; r_a0 <= '0; r_a1 <= '0; r_b <= 32'sd65536; r_dt <= 31'd66;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_SLOPE: r_slope <= i_cfg_data;
                REG_GAIN:  r_gain  <= i_cfg_data;
                REG_PHI:   r_phi   <= i_cfg_data[30:0];
                REG_SATMD: r_satmd <= i_cfg_data[0];
                REG_A0:    r_a0    <= i_cfg_data;
                REG_A1:    r_a1    <= i_cfg_data;
                REG_B:     r_b     <= i_cfg_data;
                REG_DT:    r_dt    <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    smc_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_sts(sts), .o_cmd(cmd)
    );

    smc_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts),
        .i_ref(i_reference), .i_meas(i_measured),
        .i_slope(r_slope), .i_gain(r_gain), .i_phi(r_phi), .i_satmd(r_satmd),
        .i_a0(r_a0), .i_a1(r_a1), .i_b(r_b), .i_dt(r_dt),
        .o_drive, .o_surface
    );

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> !sts.busy)
        else $error("engine busy after accept");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_drive)))
        else $error("output word dropped");
endmodule
